// File: hw/rtl/lamt_pkg.sv
// ----------------------------------------------------------------------------
// lamt_pkg
// Shared types and constants for the largest-at-most take table: state
// encoding, op codes and the command/status bundles between control and
// datapath.
// ----------------------------------------------------------------------------
package lamt_pkg;

  localparam int VALUE_W = 31;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_TAKE_RD,
    S_TAKE_MV,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // latch op and value, restart the scan
    logic ins;       // insert cycle: append if not full, record drop flag
    logic scan;      // issue next scan read
    logic take_rd;   // read the last occupied slot
    logic take_mv;   // move last slot into the hole, shrink the count
    logic res_load;  // load the output registers
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic have;
  } sts_t;

endpackage

// File: hw/rtl/lamt_ctrl.sv
// ----------------------------------------------------------------------------
// lamt_ctrl
// Controller state machine: sequences insert, scan and take steps and owns
// the input ready and output valid handshake signals.
// ----------------------------------------------------------------------------
module lamt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_op,
  input  logic            out_ready,
  input  lamt_pkg::sts_t  sts,
  output logic            in_ready,
  output logic            out_valid,
  output lamt_pkg::cmd_t  cmd
);

  lamt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lamt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == lamt_pkg::OP_QUERY) ? lamt_pkg::S_SCAN : lamt_pkg::S_INS;
        end
      end
      lamt_pkg::S_INS: state_nxt = lamt_pkg::S_DONE;
      lamt_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = sts.have ? lamt_pkg::S_TAKE_RD : lamt_pkg::S_DONE;
        end
      end
      lamt_pkg::S_TAKE_RD: state_nxt = lamt_pkg::S_TAKE_MV;
      lamt_pkg::S_TAKE_MV: state_nxt = lamt_pkg::S_DONE;
      lamt_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = lamt_pkg::S_IDLE;
        end
      end
      default: state_nxt = lamt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      lamt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lamt_pkg::S_INS:     cmd.ins      = 1'b1;
      lamt_pkg::S_SCAN:    cmd.scan     = 1'b1;
      lamt_pkg::S_TAKE_RD: cmd.take_rd  = 1'b1;
      lamt_pkg::S_TAKE_MV: cmd.take_mv  = 1'b1;
      lamt_pkg::S_DONE:    cmd.res_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lamt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/lamt_dpath.sv
// ----------------------------------------------------------------------------
// lamt_dpath
// Datapath: packed value memory with fill count, scan with best-candidate
// tracking, hole fill on take, and the output word registers.
// ----------------------------------------------------------------------------
module lamt_dpath #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10,
  parameter int CW       = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lamt_pkg::cmd_t                cmd,
  input  logic                          in_op,
  input  logic [lamt_pkg::VALUE_W-1:0]  in_value,
  output lamt_pkg::sts_t                sts,
  output logic                          out_found,
  output logic [lamt_pkg::VALUE_W-1:0]  out_taken_value,
  output logic                          out_insert_dropped
);

  localparam int VW = lamt_pkg::VALUE_W;

  // entries live packed in slots 0 .. count-1
  logic [VW-1:0] mem [CAPACITY];

  logic [VW-1:0] value_r, rd_data_r, best_r;
  logic          op_r, drop_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic          have_r, have_nxt;
  logic [AW-1:0] rd_idx_r, best_slot_r;
  logic [CW-1:0] last_idx;
  logic          full, issue, hit;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [VW-1:0] wr_data;

  assign full     = (count_r == CW'(CAPACITY));
  assign issue    = cmd.scan && (idx_r < count_r);
  assign last_idx = count_r - CW'(1);
  assign hit      = pend_r && (rd_data_r <= value_r) && (!have_r || (rd_data_r > best_r));

  assign rd_addr = cmd.take_rd ? last_idx[AW-1:0] : idx_r[AW-1:0];
  assign wr_en   = (cmd.ins && !full) || cmd.take_mv;
  assign wr_addr = cmd.take_mv ? best_slot_r : count_r[AW-1:0];
  assign wr_data = cmd.take_mv ? rd_data_r : value_r;

  assign sts.scan_done = !(idx_r < count_r) && !pend_r;
  assign sts.have      = have_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins && !full) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.take_mv) begin
      count_nxt = last_idx;
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    pend_nxt = issue;
    have_nxt = have_r;
    if (cmd.load) begin
      idx_nxt  = '0;
      have_nxt = 1'b0;
    end else if (issue) begin
      idx_nxt = idx_r + CW'(1);
    end
    if (hit) begin
      have_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      op_r    <= in_op;
    end
    if (cmd.ins) begin
      drop_r <= full;
    end
    if (issue) begin
      rd_idx_r <= idx_r[AW-1:0];
    end
    if (hit) begin
      best_r      <= rd_data_r;
      best_slot_r <= rd_idx_r;
    end
    if (cmd.res_load) begin
      out_found          <= (op_r == lamt_pkg::OP_QUERY) && have_r;
      out_taken_value    <= ((op_r == lamt_pkg::OP_QUERY) && have_r) ? best_r : '0;
      out_insert_dropped <= (op_r == lamt_pkg::OP_INSERT) && drop_r;
    end
  end

endmodule

// File: hw/rtl/largest_at_most_take_table_core.sv
// ----------------------------------------------------------------------------
// largest_at_most_take_table_core
// Multiset table: insert stores a value (or drops it when full), query
// removes and returns the largest stored value at or below the limit. One
// result word per item. An insert passes through load, insert and result
// load; a query scans each occupied slot through one memory read port, then
// on a hit reads the last slot and moves it into the hole before the result
// load, so query time grows with the fill count. One item at a time: the
// next item is accepted once the result is in the output register, which
// loads only when no earlier result is still unread. Reset: synchronous,
// clears the fill count and control; memory contents need no clearing.
// ----------------------------------------------------------------------------
module largest_at_most_take_table_core #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [lamt_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [lamt_pkg::VALUE_W-1:0]  out_taken_value,
  output logic                          out_insert_dropped
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  lamt_pkg::cmd_t cmd;
  lamt_pkg::sts_t sts;

  lamt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lamt_dpath #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_op              (in_op),
    .in_value           (in_value),
    .sts                (sts),
    .out_found          (out_found),
    .out_taken_value    (out_taken_value),
    .out_insert_dropped (out_insert_dropped)
  );

  // a result word never claims both a take and a refused insert
  a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_insert_dropped))
    else $error("found and insert_dropped both set");

  // not found reads as zero
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_taken_value == '0))
    else $error("taken_value nonzero without found");

  // one item in flight: after an accept the input stays closed
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while busy");

endmodule
